[sv/mrd_pkg.sv]
// ----------------------------------------------------------------------------
// mrd_pkg
// shared widths, field numbers and status codes of the message record deframer
// ----------------------------------------------------------------------------
`default_nettype none

package mrd_pkg;

    // record offset counter width, saturating
    localparam int OFFSET_WIDTH = 16;
    localparam int CONSUMED_WIDTH = 16;
    localparam int LIMIT_WIDTH = 16;
    // sum width for the fit compares: offset plus a 16-bit span, one carry bit
    localparam int SUM_WIDTH = ((OFFSET_WIDTH > 16) ? OFFSET_WIDTH : 16) + 1;

    localparam int INT_BYTES = 4;
    localparam int DBL_BYTES = 8;

    // field numbers
    localparam logic [3:0] FIELD_TOTAL_LEN = 4'd0;
    localparam logic [3:0] FIELD_ID        = 4'd1;
    localparam logic [3:0] FIELD_MSG_TYPE  = 4'd2;
    localparam logic [3:0] FIELD_DATA_TYPE = 4'd3;
    localparam logic [3:0] FIELD_STR_FIRST = 4'd4;
    localparam logic [3:0] FIELD_STR_LAST  = 4'd7;
    localparam logic [3:0] FIELD_DBL_FIRST = 4'd8;
    localparam logic [3:0] FIELD_DBL_LAST  = 4'd10;
    localparam logic [3:0] FIELD_LAST      = 4'd11;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERRUN = 2'd1;
    localparam logic [1:0] ST_DISCARD = 2'd2;

    // length-prefixed string fields
    function automatic logic is_str_field(input logic [3:0] f);
        return ((f >= FIELD_STR_FIRST) && (f <= FIELD_STR_LAST)) || (f == FIELD_LAST);
    endfunction

endpackage

`default_nettype wire

[sv/message_record_deframer.sv]
// ----------------------------------------------------------------------------
// message_record_deframer
// byte-serial parser for one serialized message record with overrun checking
// ----------------------------------------------------------------------------
//
//  channel   | dir | payload                                       | transfer when
//  ----------+-----+-----------------------------------------------+----------------------
//  s_axis    | in  | tdata: data_byte; tuser: record_start         | s_tvalid & s_tready
//  m_axis    | out | tdata: byte, word, consumed; tuser/tlast flags| m_tvalid & m_tready
//  cfg       | in  | cfg_data: buffer_limit                        | cfg_valid & cfg_ready
//
//  one byte per clock while results are drained; each result appears in the
//  cycle after its input transfer, from a single output register
//  the parse state is a handful of counters updated in the same cycle the
//  byte is taken, so consecutive bytes need no bubbles
//  s_tready is high whenever the output register is empty or being drained;
//  an output stall holds s_tready low only while a result waits
//  reset clears the parse state (parser idle) and sets buffer_limit to 65535
//  cfg_ready is always high; the limit is sampled for every byte
//
`default_nettype none

module message_record_deframer
    import mrd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] record_start
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [7:0] byte_out, [39:8] word_value,
                                        // [55:40] bytes_consumed
    output logic [7:0]       m_tuser,   // [3:0] field_index, [4] in_length_prefix,
                                        // [5] field_end, [7:6] status
    output logic             m_tlast,   // record_end
    // buffer_limit write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

    // parse state
    logic [3:0]              field_reg, field_next;
    logic                    prefix_reg, prefix_next;
    logic [3:0]              bif_reg, bif_next;       // bytes taken of the current item
    logic [15:0]             remain_reg, remain_next; // string content bytes left
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic [31:0]             word_reg, word_next;
    logic                    active_reg, active_next;
    logic [LIMIT_WIDTH-1:0]  limit_reg;

    // output register
    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic [7:0]  out_user_reg;
    logic        out_last_reg;

    logic accept;

    // view of the state after a possible record_start restart
    logic [3:0]              cur_field;
    logic                    cur_prefix;
    logic [3:0]              cur_bif;
    logic [15:0]             cur_remain;
    logic [OFFSET_WIDTH-1:0] cur_offset;
    logic [31:0]             cur_word;
    logic                    cur_active;

    logic [7:0]  din;
    logic        is_int, is_one, is_dbl, is_str, known;
    logic        content, is_word;
    logic [3:0]  item_size;
    logic [3:0]  bif_inc;
    logic [15:0] span;
    logic [SUM_WIDTH-1:0] fit_sum;
    logic [SUM_WIDTH-1:0] len_sum;
    logic [SUM_WIDTH-1:0] limit_ext;
    logic [OFFSET_WIDTH-1:0] offset_sat;
    logic [31:0] word_ins;
    logic        len_bad;
    logic        advance;
    logic [3:0]  field_inc;

    // result fields
    logic [3:0]  res_field;
    logic        res_prefix;
    logic        res_field_end;
    logic [31:0] res_word;
    logic        res_record_end;
    logic [1:0]  res_status;
    logic [15:0] res_consumed;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign din       = s_tdata;

    always_comb
    begin
        // record_start aborts whatever is in progress
        if (s_tuser[0])
        begin
            cur_field  = FIELD_TOTAL_LEN;
            cur_prefix = 1'b0;
            cur_bif    = '0;
            cur_remain = '0;
            cur_offset = '0;
            cur_word   = '0;
            cur_active = 1'b1;
        end
        else
        begin
            cur_field  = field_reg;
            cur_prefix = prefix_reg;
            cur_bif    = bif_reg;
            cur_remain = remain_reg;
            cur_offset = offset_reg;
            cur_word   = word_reg;
            cur_active = active_reg;
        end

        // field classification
        is_int  = (cur_field <= FIELD_ID);
        is_one  = (cur_field == FIELD_MSG_TYPE) || (cur_field == FIELD_DATA_TYPE);
        is_dbl  = (cur_field >= FIELD_DBL_FIRST) && (cur_field <= FIELD_DBL_LAST);
        is_str  = is_str_field(cur_field);
        known   = is_int || is_one || is_dbl || is_str;
        content = is_str && !cur_prefix;
        is_word = is_int || (is_str && cur_prefix);

        if (is_word)
            item_size = 4'(INT_BYTES);
        else if (is_dbl)
            item_size = 4'(DBL_BYTES);
        else
            item_size = 4'd1;

        bif_inc = cur_bif + 4'd1;

        // bytes this item still needs, at least one
        if (content)
            span = (cur_remain == '0) ? 16'd1 : cur_remain;
        else if (cur_bif < item_size)
            span = 16'(item_size - cur_bif);
        else
            span = 16'd1;

        limit_ext = SUM_WIDTH'(limit_reg);
        fit_sum   = SUM_WIDTH'(cur_offset) + SUM_WIDTH'(span);

        offset_sat = (cur_offset == OFFSET_MAX) ? cur_offset
                                                : cur_offset + OFFSET_WIDTH'(1);

        // little-endian word assembly
        word_ins = (cur_bif == '0) ? '0 : cur_word;
        word_ins[{cur_bif[1:0], 3'b000} +: 8] = word_ins[{cur_bif[1:0], 3'b000} +: 8] | din;

        // declared string length must be non-negative and fit behind this byte
        len_sum = SUM_WIDTH'(offset_sat) + SUM_WIDTH'(word_ins[15:0]);
        len_bad = word_ins[31] || (|word_ins[30:16]) || (len_sum > limit_ext);

        field_inc = cur_field + 4'd1;

        // defaults: state as seen, empty result
        field_next  = cur_field;
        prefix_next = cur_prefix;
        bif_next    = cur_bif;
        remain_next = cur_remain;
        offset_next = cur_offset;
        word_next   = cur_word;
        active_next = cur_active;

        res_field      = '0;
        res_prefix     = 1'b0;
        res_field_end  = 1'b0;
        res_word       = '0;
        res_record_end = 1'b0;
        res_status     = ST_OK;
        res_consumed   = '0;
        advance        = 1'b0;

        if (!cur_active)
        begin
            res_status = ST_DISCARD;
        end
        else
        begin
            res_field    = cur_field;
            res_prefix   = is_str && cur_prefix;
            res_consumed = CONSUMED_WIDTH'(offset_sat);

            if (!known || (fit_sum > limit_ext))
            begin
                res_status  = ST_OVERRUN;
                active_next = 1'b0;
            end
            else
            begin
                offset_next = offset_sat;
                if (content)
                begin
                    remain_next = cur_remain - 16'd1;
                    if (remain_next == '0)
                        advance = 1'b1;
                end
                else
                begin
                    if (is_word)
                    begin
                        word_next = word_ins;
                        res_word  = word_ins;
                    end
                    bif_next = bif_inc;
                    if (bif_inc >= item_size)
                    begin
                        if (is_word && cur_prefix)
                        begin
                            if (len_bad)
                            begin
                                res_word    = '0;
                                res_status  = ST_OVERRUN;
                                active_next = 1'b0;
                            end
                            else if (word_ins == '0)
                            begin
                                // empty string ends on its last prefix byte
                                advance = 1'b1;
                            end
                            else
                            begin
                                prefix_next = 1'b0;
                                bif_next    = '0;
                                remain_next = word_ins[15:0];
                            end
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                end
            end
        end

        // step to the next field, or close the record after the value string
        if (advance)
        begin
            res_field_end = 1'b1;
            bif_next      = '0;
            word_next     = '0;
            remain_next   = '0;
            if (cur_field >= FIELD_LAST)
            begin
                res_record_end = 1'b1;
                active_next    = 1'b0;
                field_next     = FIELD_TOTAL_LEN;
                prefix_next    = 1'b0;
            end
            else
            begin
                field_next  = field_inc;
                prefix_next = is_str_field(field_inc);
            end
        end
    end

    // control and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg     <= FIELD_TOTAL_LEN;
            prefix_reg    <= 1'b0;
            bif_reg       <= '0;
            remain_reg    <= '0;
            offset_reg    <= '0;
            word_reg      <= '0;
            active_reg    <= 1'b0;
            limit_reg     <= {LIMIT_WIDTH{1'b1}};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            if (accept)
            begin
                field_reg  <= field_next;
                prefix_reg <= prefix_next;
                bif_reg    <= bif_next;
                remain_reg <= remain_next;
                offset_reg <= offset_next;
                word_reg   <= word_next;
                active_reg <= active_next;
            end
            if (s_tready)
                out_valid_reg <= s_tvalid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {res_consumed, res_word, din};
            out_user_reg <= {res_status, res_field_end, res_prefix, res_field};
            out_last_reg <= res_record_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[sv/mrd_checker.sv]
// ----------------------------------------------------------------------------
// mrd_checker
// port-level checks of the message record deframer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mrd_checker
    import mrd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [7:0]  m_tuser,
    input wire logic        m_tlast
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("result changed while stalled");

    // input side is open whenever no result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input blocked with empty output register");

    // record end only on the accepted last byte of the value string
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[5] && (m_tuser[3:0] == FIELD_LAST)
            && (m_tuser[7:6] == ST_OK))
    else $error("record end outside the value string");

    // discarded bytes carry only the byte itself
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[7:6] == ST_DISCARD) |-> (m_tuser[5:0] == '0)
            && (m_tdata[55:8] == '0) && !m_tlast)
    else $error("discarded byte with parse fields set");

    // a length prefix byte belongs to a string field
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4] |-> is_str_field(m_tuser[3:0]))
    else $error("length prefix outside a string field");

endmodule

bind message_record_deframer mrd_checker u_mrd_checker (.*);

`default_nettype wire
